// ----- rtl/rpqe_pkg.sv -----
// ----------------------------------------------------------------------------
// rpqe_pkg
// Shared types, codes and constant tables of the rigid pose quaternion engine.
// ----------------------------------------------------------------------------
package rpqe_pkg;

    // Default parameter values
    localparam int QUAT_FRAC_BITS_DEF = 30;
    localparam int ANGLE_BITS_DEF     = 16;

    // pi/2 in unsigned Q1.30
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // Opcodes and axis codes
    localparam logic [1:0] OP_ROTATE   = 2'd0;
    localparam logic [1:0] OP_SET_POS  = 2'd1;
    localparam logic [1:0] OP_SET_QUAT = 2'd2;
    localparam logic [1:0] AXIS_NONE   = 2'd3;

    // Multiplier operand selects
    localparam logic [2:0] MUL_NONE = 3'd0;
    localparam logic [2:0] MUL_ANG  = 3'd1;  // reduced angle * pi/2
    localparam logic [2:0] MUL_XX   = 3'd2;  // x * x
    localparam logic [2:0] MUL_X2T  = 3'd3;  // x^2 * series term
    localparam logic [2:0] MUL_NREC = 3'd4;  // numerator * reciprocal
    localparam logic [2:0] MUL_QD   = 3'd5;  // quotient estimate * divisor
    localparam logic [2:0] MUL_XT   = 3'd6;  // x * sine series
    localparam logic [2:0] MUL_PROD = 3'd7;  // quaternion component product

    // Write-back operations on the registered product
    localparam logic [3:0] WB_NONE = 4'd0;
    localparam logic [3:0] WB_X    = 4'd1;
    localparam logic [3:0] WB_X2   = 4'd2;
    localparam logic [3:0] WB_N    = 4'd3;
    localparam logic [3:0] WB_QE   = 4'd4;
    localparam logic [3:0] WB_QUO  = 4'd5;
    localparam logic [3:0] WB_T    = 4'd6;
    localparam logic [3:0] WB_S    = 4'd7;
    localparam logic [3:0] WB_C    = 4'd8;
    localparam logic [3:0] WB_ACC  = 4'd9;

    // Series step indexes: sine steps first, then cosine steps
    localparam logic [3:0] H_SIN_LAST = 4'd6;
    localparam logic [3:0] H_COS_FIRST = 4'd7;
    localparam logic [3:0] H_COS_LAST = 4'd14;

    // Controller to datapath command
    typedef struct packed {
        logic              load;
        logic [2:0]        mul_op;
        logic [3:0]        wb_op;
        logic [3:0]        kidx;
        logic [1:0]        ia;
        logic [1:0]        ib;
        logic signed [2:0] coef;
        logic              acc_clr;
        logic              rnd_en;
        logic [3:0]        rnd_dst;
        logic              mat;
        logic              commit;
        logic [1:0]        row;
    } t_cmd;

    // One product term of a sum
    typedef struct packed {
        logic [1:0]        ia;
        logic [1:0]        ib;
        logic signed [2:0] coef;
    } t_term;

    // Series divisor k*(k-1)
    function automatic logic [7:0] series_den(input logic [3:0] kidx);
        logic [7:0] d;
        unique case (kidx)
            4'd0:    d = 8'd210;
            4'd1:    d = 8'd156;
            4'd2:    d = 8'd110;
            4'd3:    d = 8'd72;
            4'd4:    d = 8'd42;
            4'd5:    d = 8'd20;
            4'd6:    d = 8'd6;
            4'd7:    d = 8'd240;
            4'd8:    d = 8'd182;
            4'd9:    d = 8'd132;
            4'd10:   d = 8'd90;
            4'd11:   d = 8'd56;
            4'd12:   d = 8'd30;
            4'd13:   d = 8'd12;
            4'd14:   d = 8'd2;
            default: d = 8'd1;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor)
    function automatic logic [31:0] series_rcp(input logic [3:0] kidx);
        logic [31:0] m;
        unique case (kidx)
            4'd0:    m = 32'd20452225;
            4'd1:    m = 32'd27531841;
            4'd2:    m = 32'd39045157;
            4'd3:    m = 32'd59652323;
            4'd4:    m = 32'd102261126;
            4'd5:    m = 32'd214748364;
            4'd6:    m = 32'd715827882;
            4'd7:    m = 32'd17895697;
            4'd8:    m = 32'd23598721;
            4'd9:    m = 32'd32537631;
            4'd10:   m = 32'd47721858;
            4'd11:   m = 32'd76695844;
            4'd12:   m = 32'd143165576;
            4'd13:   m = 32'd357913941;
            4'd14:   m = 32'd2147483648;
            default: m = 32'd0;
        endcase
        return m;
    endfunction

    // Term j of entry e: Hamilton product (mat = 0) or rotation matrix (mat = 1)
    function automatic t_term term_info(input logic mat, input logic [3:0] e,
                                        input logic [1:0] j);
        t_term t;
        logic  neg;
        t = '0;
        neg = 1'b0;
        if (!mat) begin
            t.ia = j;
            t.ib = e[1:0] ^ j;
            unique case ({e[1:0], j})
                4'b0001, 4'b0010, 4'b0011, 4'b0111, 4'b1001, 4'b1110: neg = 1'b1;
                default: neg = 1'b0;
            endcase
            t.coef = neg ? -3'sd1 : 3'sd1;
        end else begin
            unique case ({e, j})
                6'd0:    t = '{2'd0, 2'd0,  3'sd1};
                6'd1:    t = '{2'd1, 2'd1,  3'sd1};
                6'd2:    t = '{2'd2, 2'd2, -3'sd1};
                6'd3:    t = '{2'd3, 2'd3, -3'sd1};
                6'd4:    t = '{2'd1, 2'd2,  3'sd2};
                6'd5:    t = '{2'd0, 2'd3, -3'sd2};
                6'd8:    t = '{2'd1, 2'd3,  3'sd2};
                6'd9:    t = '{2'd0, 2'd2,  3'sd2};
                6'd12:   t = '{2'd1, 2'd2,  3'sd2};
                6'd13:   t = '{2'd0, 2'd3,  3'sd2};
                6'd16:   t = '{2'd0, 2'd0,  3'sd1};
                6'd17:   t = '{2'd1, 2'd1, -3'sd1};
                6'd18:   t = '{2'd2, 2'd2,  3'sd1};
                6'd19:   t = '{2'd3, 2'd3, -3'sd1};
                6'd20:   t = '{2'd2, 2'd3,  3'sd2};
                6'd21:   t = '{2'd0, 2'd1, -3'sd2};
                6'd24:   t = '{2'd1, 2'd3,  3'sd2};
                6'd25:   t = '{2'd0, 2'd2, -3'sd2};
                6'd28:   t = '{2'd2, 2'd3,  3'sd2};
                6'd29:   t = '{2'd0, 2'd1,  3'sd2};
                6'd32:   t = '{2'd0, 2'd0,  3'sd1};
                6'd33:   t = '{2'd1, 2'd1, -3'sd1};
                6'd34:   t = '{2'd2, 2'd2, -3'sd1};
                6'd35:   t = '{2'd3, 2'd3,  3'sd1};
                default: t = '0;
            endcase
        end
        return t;
    endfunction

endpackage

// ----- rtl/rpqe_ctrl.sv -----
// ----------------------------------------------------------------------------
// rpqe_ctrl
// Sequencer: steps the shared multiplier through the sine/cosine series,
// the Hamilton product and the matrix sums, then hands out three rows.
// ----------------------------------------------------------------------------
module rpqe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_opcode,
    input  logic [1:0]    i_axis,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [1:0]    o_row_index,
    output logic          o_last_row,
    output rpqe_pkg::t_cmd o_cmd
);
    import rpqe_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PRE    = 3'd1;
    localparam logic [2:0] S_HORN   = 3'd2;
    localparam logic [2:0] S_SFIN   = 3'd3;
    localparam logic [2:0] S_CFIN   = 3'd4;
    localparam logic [2:0] S_PROD   = 3'd5;
    localparam logic [2:0] S_COMMIT = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    // product phase: 4 terms per entry, followed by trailing accumulate and round steps
    localparam logic [5:0] MUL_END_ROT = 6'd16;
    localparam logic [5:0] MUL_END_MAT = 6'd36;
    localparam logic [1:0] LAST_ROW    = 2'd2;

    logic [2:0] r_state, n_state;
    logic [2:0] r_step, n_step;
    logic [3:0] r_h, n_h;
    logic [5:0] r_cnt, n_cnt;
    logic       r_mat, n_mat;
    logic [1:0] r_row, n_row;

    logic [5:0] w_mul_end;
    logic [5:0] w_c1;
    logic [5:0] w_c5;
    t_term      w_tm;
    t_term      w_ta;

    assign w_mul_end = r_mat ? MUL_END_MAT : MUL_END_ROT;
    assign w_c1      = r_cnt - 6'd1;
    assign w_c5      = r_cnt - 6'd5;
    assign w_tm      = term_info(r_mat, r_cnt[5:2], r_cnt[1:0]);
    assign w_ta      = term_info(r_mat, w_c1[5:2], w_c1[1:0]);

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_row_index = r_row;
    assign o_last_row  = (r_row == LAST_ROW);

    // next state and command
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_h     = r_h;
        n_cnt   = r_cnt;
        n_mat   = r_mat;
        n_row   = r_row;
        o_cmd   = '0;
        o_cmd.row  = r_row;
        o_cmd.mat  = r_mat;
        o_cmd.kidx = r_h;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_opcode == OP_ROTATE && i_axis != AXIS_NONE) begin
                        n_state = S_PRE;
                        n_step  = 3'd0;
                    end else begin
                        n_state = S_PROD;
                        n_mat   = 1'b1;
                        n_cnt   = 6'd0;
                    end
                end
            end
            S_PRE: begin
                n_step = r_step + 3'd1;
                unique case (r_step)
                    3'd0:    o_cmd.mul_op = MUL_ANG;
                    3'd1:    o_cmd.wb_op  = WB_X;
                    3'd2:    o_cmd.mul_op = MUL_XX;
                    default: begin
                        o_cmd.wb_op = WB_X2;
                        n_state     = S_HORN;
                        n_h         = 4'd0;
                        n_step      = 3'd0;
                    end
                endcase
            end
            S_HORN: begin
                n_step = r_step + 3'd1;
                unique case (r_step)
                    3'd0:    o_cmd.mul_op = MUL_X2T;
                    3'd1:    o_cmd.wb_op  = WB_N;
                    3'd2:    o_cmd.mul_op = MUL_NREC;
                    3'd3:    o_cmd.wb_op  = WB_QE;
                    3'd4:    o_cmd.mul_op = MUL_QD;
                    3'd5:    o_cmd.wb_op  = WB_QUO;
                    default: begin
                        o_cmd.wb_op = WB_T;
                        n_step      = 3'd0;
                        if (r_h == H_SIN_LAST) begin
                            n_state = S_SFIN;
                        end else if (r_h == H_COS_LAST) begin
                            n_state = S_CFIN;
                        end else begin
                            n_h = r_h + 4'd1;
                        end
                    end
                endcase
            end
            S_SFIN: begin
                if (r_step == 3'd0) begin
                    o_cmd.mul_op = MUL_XT;
                    n_step       = 3'd1;
                end else begin
                    o_cmd.wb_op = WB_S;
                    n_step      = 3'd0;
                    n_h         = H_COS_FIRST;
                    n_state     = S_HORN;
                end
            end
            S_CFIN: begin
                o_cmd.wb_op = WB_C;
                n_state     = S_PROD;
                n_mat       = 1'b0;
                n_cnt       = 6'd0;
            end
            S_PROD: begin
                // issue term cnt, accumulate term cnt-1, round entry done earlier
                if (r_cnt < w_mul_end) begin
                    o_cmd.mul_op = MUL_PROD;
                    o_cmd.ia     = w_tm.ia;
                    o_cmd.ib     = w_tm.ib;
                end
                if (r_cnt != 6'd0 && r_cnt <= w_mul_end) begin
                    o_cmd.wb_op   = WB_ACC;
                    o_cmd.coef    = w_ta.coef;
                    o_cmd.acc_clr = (w_c1[1:0] == 2'd0);
                end
                if (r_cnt >= 6'd5 && r_cnt[1:0] == 2'd1) begin
                    o_cmd.rnd_en  = 1'b1;
                    o_cmd.rnd_dst = w_c5[5:2];
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == w_mul_end + 6'd1) begin
                    if (r_mat) begin
                        n_state = S_OUT;
                        n_row   = 2'd0;
                    end else begin
                        n_state = S_COMMIT;
                    end
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_PROD;
                n_mat        = 1'b1;
                n_cnt        = 6'd0;
            end
            S_OUT: begin
                if (i_ready) begin
                    if (r_row == LAST_ROW) begin
                        n_state = S_IDLE;
                        n_row   = 2'd0;
                    end else begin
                        n_row = r_row + 2'd1;
                    end
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 3'd0;
            r_h     <= 4'd0;
            r_cnt   <= 6'd0;
            r_mat   <= 1'b0;
            r_row   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_h     <= n_h;
            r_cnt   <= n_cnt;
            r_mat   <= n_mat;
            r_row   <= n_row;
        end
    end

endmodule

// ----- rtl/rpqe_dp.sv -----
// ----------------------------------------------------------------------------
// rpqe_dp
// Datapath: pose registers, one shared 33x33 signed multiplier with a
// registered product, series and accumulate write-back, matrix store.
// ----------------------------------------------------------------------------
module rpqe_dp #(
    parameter int QUAT_FRAC_BITS = rpqe_pkg::QUAT_FRAC_BITS_DEF,
    parameter int ANGLE_BITS     = rpqe_pkg::ANGLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rpqe_pkg::t_cmd     i_cmd,
    input  logic [1:0]         i_opcode,
    input  logic [1:0]         i_axis,
    input  logic signed [15:0] i_angle,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_quat_w,
    input  logic signed [31:0] i_quat_x,
    input  logic signed [31:0] i_quat_y,
    input  logic signed [31:0] i_quat_z,
    output logic signed [31:0] o_rot_col0,
    output logic signed [31:0] o_rot_col1,
    output logic signed [31:0] o_rot_col2,
    output logic signed [31:0] o_translation
);
    import rpqe_pkg::*;

    localparam int SH        = 30 - QUAT_FRAC_BITS;
    localparam int ANG_SHIFT = 31 - ANGLE_BITS;
    localparam logic [31:0] RND_SC = 32'((64'd1 << SH) >> 1);
    localparam logic signed [67:0] HALF_F = 68'(64'd1 << (QUAT_FRAC_BITS - 1));
    localparam logic signed [31:0] ONE_F  = 32'(64'd1 << QUAT_FRAC_BITS);
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
    localparam logic signed [67:0] SAT_MAX = 68'sd2147483647;
    localparam logic signed [67:0] SAT_MIN = -68'sd2147483648;

    // pose state
    logic signed [31:0] r_q [4];
    logic signed [31:0] r_loc [3];

    // working registers
    logic signed [15:0] r_angle;
    logic [1:0]         r_axis;
    logic signed [65:0] r_prod;
    logic [30:0]        r_x;
    logic [31:0]        r_x2;
    logic [30:0]        r_t;
    logic [31:0]        r_n;
    logic [31:0]        r_qe;
    logic [31:0]        r_quo;
    logic [31:0]        r_s;
    logic signed [31:0] r_rv [4];
    logic signed [67:0] r_acc;
    logic signed [31:0] r_nq [4];
    logic signed [31:0] r_m [9];

    logic [31:0]        w_p;
    logic signed [32:0] w_ma;
    logic signed [32:0] w_mb;
    logic signed [65:0] w_prod;
    logic [65:0]        w_r30s;
    logic [35:0]        w_round30;
    logic [7:0]         w_den;
    logic [33:0]        w_lim;
    logic [35:0]        w_s_sum;
    logic [31:0]        w_c;
    logic signed [31:0] w_cs;
    logic signed [31:0] w_sn;
    logic signed [67:0] w_p68;
    logic signed [67:0] w_term;
    logic signed [67:0] w_rnd_sum;
    logic signed [67:0] w_rnd_sh;
    logic signed [31:0] w_rnd;
    logic [3:0]         w_base;

    // reduced angle: two quadrant bits over a 30-bit fraction of a quadrant
    assign w_p   = 32'({{16{r_angle[15]}}, r_angle} << ANG_SHIFT);
    assign w_den = series_den(i_cmd.kidx);

    // multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (i_cmd.mul_op)
            MUL_ANG: begin
                w_ma = signed'({3'b0, w_p[29:0]});
                w_mb = signed'({2'b0, HALF_PI_Q30});
            end
            MUL_XX: begin
                w_ma = signed'({2'b0, r_x});
                w_mb = signed'({2'b0, r_x});
            end
            MUL_X2T: begin
                w_ma = signed'({1'b0, r_x2});
                w_mb = signed'({2'b0, r_t});
            end
            MUL_NREC: begin
                w_ma = signed'({1'b0, r_n});
                w_mb = signed'({1'b0, series_rcp(i_cmd.kidx)});
            end
            MUL_QD: begin
                w_ma = signed'({1'b0, r_qe});
                w_mb = signed'({25'b0, w_den});
            end
            MUL_XT: begin
                w_ma = signed'({2'b0, r_x});
                w_mb = signed'({2'b0, r_t});
            end
            MUL_PROD: begin
                w_ma = {r_q[i_cmd.ia][31], r_q[i_cmd.ia]};
                w_mb = i_cmd.mat ? {r_q[i_cmd.ib][31], r_q[i_cmd.ib]}
                                 : {r_rv[i_cmd.ib][31], r_rv[i_cmd.ib]};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    // round half up at 30 fraction bits (series values are never negative)
    assign w_r30s    = r_prod + 66'sd536870912;
    assign w_round30 = w_r30s[65:30];

    // remainder check of the reciprocal quotient estimate
    assign w_lim   = r_prod[33:0] + {26'b0, w_den};
    assign w_s_sum = w_round30 + {4'b0, RND_SC};
    assign w_c     = 32'(({1'b0, r_t} + RND_SC) >> SH);

    // quadrant unfold of cosine and sine
    always_comb begin
        unique case (w_p[31:30])
            2'd0: begin w_cs = signed'(w_c);  w_sn = signed'(r_s);  end
            2'd1: begin w_cs = -signed'(r_s); w_sn = signed'(w_c);  end
            2'd2: begin w_cs = -signed'(w_c); w_sn = -signed'(r_s); end
            default: begin w_cs = signed'(r_s); w_sn = -signed'(w_c); end
        endcase
    end

    // scaled accumulate term
    assign w_p68 = {{2{r_prod[65]}}, r_prod};
    always_comb begin
        unique case (i_cmd.coef)
            3'sd1:   w_term = w_p68;
            -3'sd1:  w_term = -w_p68;
            3'sd2:   w_term = w_p68 <<< 1;
            -3'sd2:  w_term = -(w_p68 <<< 1);
            default: w_term = '0;
        endcase
    end

    // round half up to the output format, then saturate
    assign w_rnd_sum = r_acc + HALF_F;
    assign w_rnd_sh  = w_rnd_sum >>> QUAT_FRAC_BITS;
    always_comb begin
        if (w_rnd_sh > SAT_MAX) begin
            w_rnd = 32'sh7FFF_FFFF;
        end else if (w_rnd_sh < SAT_MIN) begin
            w_rnd = -32'sh8000_0000;
        end else begin
            w_rnd = w_rnd_sh[31:0];
        end
    end

    // pose state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q[0]   <= ONE_F;
            r_q[1]   <= '0;
            r_q[2]   <= '0;
            r_q[3]   <= '0;
            r_loc[0] <= '0;
            r_loc[1] <= '0;
            r_loc[2] <= '0;
        end else begin
            if (i_cmd.load && i_opcode == OP_SET_POS) begin
                r_loc[0] <= i_pos_x;
                r_loc[1] <= i_pos_y;
                r_loc[2] <= i_pos_z;
            end
            if (i_cmd.load && i_opcode == OP_SET_QUAT) begin
                r_q[0] <= i_quat_w;
                r_q[1] <= i_quat_x;
                r_q[2] <= i_quat_y;
                r_q[3] <= i_quat_z;
            end
            if (i_cmd.commit) begin
                for (int i = 0; i < 4; i++) begin
                    r_q[i] <= r_nq[i];
                end
            end
        end
    end

    // working registers and write-back
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (i_cmd.load) begin
            r_angle <= i_angle;
            r_axis  <= i_axis;
        end
        unique case (i_cmd.wb_op)
            WB_X:   r_x <= w_round30[30:0];
            WB_X2: begin
                r_x2 <= w_round30[31:0];
                r_t  <= ONE_Q30[30:0];
            end
            WB_N:   r_n  <= w_round30[31:0];
            WB_QE:  r_qe <= r_prod[63:32];
            WB_QUO: r_quo <= r_qe + {31'b0, ({2'b0, r_n} >= w_lim)};
            WB_T:   r_t <= (r_quo > ONE_Q30) ? 31'd0 : 31'(ONE_Q30 - r_quo);
            WB_S: begin
                r_s <= 32'(w_s_sum >> SH);
                r_t <= ONE_Q30[30:0];
            end
            WB_C: begin
                r_rv[0] <= w_cs;
                for (int i = 1; i < 4; i++) begin
                    r_rv[i] <= (r_axis == 2'(i - 1)) ? w_sn : 32'sd0;
                end
            end
            WB_ACC: r_acc <= (i_cmd.acc_clr ? 68'sd0 : r_acc) + w_term;
            default: begin
            end
        endcase
        if (i_cmd.rnd_en) begin
            if (i_cmd.mat) begin
                r_m[i_cmd.rnd_dst] <= w_rnd;
            end else begin
                r_nq[i_cmd.rnd_dst[1:0]] <= w_rnd;
            end
        end
    end

    // row select onto the result ports
    assign w_base        = {2'b0, i_cmd.row} * 4'd3;
    assign o_rot_col0    = r_m[w_base];
    assign o_rot_col1    = r_m[w_base + 4'd1];
    assign o_rot_col2    = r_m[w_base + 4'd2];
    assign o_translation = r_loc[i_cmd.row];

endmodule

// ----- rtl/rigid_pose_quaternion_engine_core.sv -----
// ----------------------------------------------------------------------------
// rigid_pose_quaternion_engine_core
// Keeps an orientation quaternion (reset identity) and a position (reset
// zero); each input item rotates about an axis, sets the position or sets
// the quaternion, and the block then sends the 3x4 transform [R | t] as
// three row transfers, row 0 first, last_row flagging row 2. One item is
// worked at a time and input ready is high only while the block is idle.
// Every product goes through one shared 33x33 multiplier with a registered
// product. Set position, set quaternion and no-op items run the matrix sums
// (nine entries of four terms) and then the row transfers; a rotate first
// runs angle reduction, the sine and cosine series (fifteen steps, dividing
// by reciprocal multiply and remainder check), series finish and the
// quaternion product, before the matrix sums and the row transfers.
// Results saturate to 32 bits and the quaternion is never renormalized.
// ----------------------------------------------------------------------------
module rigid_pose_quaternion_engine_core #(
    parameter int QUAT_FRAC_BITS = rpqe_pkg::QUAT_FRAC_BITS_DEF,
    parameter int ANGLE_BITS     = rpqe_pkg::ANGLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_opcode,
    input  logic [1:0]         i_axis,
    input  logic signed [15:0] i_angle,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_quat_w,
    input  logic signed [31:0] i_quat_x,
    input  logic signed [31:0] i_quat_y,
    input  logic signed [31:0] i_quat_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_row_index,
    output logic signed [31:0] o_rot_col0,
    output logic signed [31:0] o_rot_col1,
    output logic signed [31:0] o_rot_col2,
    output logic signed [31:0] o_translation,
    output logic               o_last_row
);
    import rpqe_pkg::*;

    t_cmd w_cmd;

    // sequencer
    rpqe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_axis      (i_axis),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_row_index (o_row_index),
        .o_last_row  (o_last_row),
        .o_cmd       (w_cmd)
    );

    // arithmetic and pose state
    rpqe_dp #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
        .ANGLE_BITS     (ANGLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_opcode      (i_opcode),
        .i_axis        (i_axis),
        .i_angle       (i_angle),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_quat_w      (i_quat_w),
        .i_quat_x      (i_quat_x),
        .i_quat_y      (i_quat_y),
        .i_quat_z      (i_quat_z),
        .o_rot_col0    (o_rot_col0),
        .o_rot_col1    (o_rot_col1),
        .o_rot_col2    (o_rot_col2),
        .o_translation (o_translation)
    );

endmodule

// ----- rtl/rpqe_checker.sv -----
// ----------------------------------------------------------------------------
// rpqe_checker
// Port-level checks of the pose engine, bound to the top level.
// ----------------------------------------------------------------------------
module rpqe_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic [1:0]         o_row_index,
    input logic               o_last_row,
    input logic signed [31:0] o_rot_col0,
    input logic signed [31:0] o_translation
);

    // no new item is taken while rows are pending
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while result rows pending");

    // an accepted item keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready right after input transfer");

    // rows follow one another without a gap
    a_row_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_row) |=>
            (o_valid && o_row_index == 2'($past(o_row_index) + 2'd1)))
        else $error("row sequence broken");

    // last flag marks row 2 only
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_row == (o_row_index == 2'd2)))
        else $error("last_row does not match row index");

    // a stalled row holds its index, column 0 and translation
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_row_index) && $stable(o_rot_col0)
             && $stable(o_translation)))
        else $error("stalled row changed");

endmodule

bind rigid_pose_quaternion_engine_core rpqe_checker u_rpqe_checker (.*);
